// File: rtl/fpba_pkg.sv
// Package for the fit-policy block allocator: field widths, codes and payload structs.
// No dependencies; the top level refers to it by scoped names.
`default_nettype none

package fpba_pkg;

    localparam int NUM_BLOCKS_DEF = 8;
    localparam int SIZE_WIDTH_DEF = 16;

    localparam int SEL_W    = 3;
    localparam int AMOUNT_W = 16;
    localparam int INDEX_W  = 3;
    localparam int REMAIN_W = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_FIT_POLICY    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCKS_IN_USE = 2'd1;

    localparam logic [3:0] BLOCKS_IN_USE_RST = 4'd8;

    typedef enum logic [1:0] {
        POLICY_FIRST = 2'd0,
        POLICY_BEST  = 2'd1,
        POLICY_WORST = 2'd2
    } policy_t;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    typedef struct packed {
        logic                command;
        logic [SEL_W-1:0]    block_select;
        logic [AMOUNT_W-1:0] amount;
        logic                batch_last;
    } request_t;

    typedef struct packed {
        logic                granted;
        logic [INDEX_W-1:0]  block_index;
        logic [REMAIN_W-1:0] remaining;
        logic                batch_end;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/fpba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/fit_policy_block_allocator.sv
// Top level, uses fpba_pkg and fpba_ram; each result lasts one cycle, no receiver stall.
// Operation: a load is written at its transfer and gives no result; an allocate scans
// limit = min(blocks_in_use, NUM_BLOCKS) capacities, then writes back and raises done.
// Busy holds off a new request until the current allocate is through, set by the
// scan that reads one capacity a cycle through the single RAM read port.
// Reset: async, active low; all capacities read as zero, policy first fit, eight in use.
`default_nettype none

module fit_policy_block_allocator #(
    parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_WIDTH = fpba_pkg::SIZE_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire fpba_pkg::request_t                  request,
    output logic                                     done,
    output fpba_pkg::result_t                        result,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [fpba_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [fpba_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_WRITE = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           policy_reg;
    logic [3:0]           in_use_reg;
    logic [NUM_BLOCKS-1:0] valid_reg;

    logic [SIZE_WIDTH-1:0] amount_reg, amount_next;
    logic                  last_reg, last_next;
    logic [CNT_W-1:0]      limit_reg, limit_next;
    logic [CNT_W-1:0]      issue_reg, issue_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic                  rd_last_reg, rd_last_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      pick_reg, pick_next;
    logic [SIZE_WIDTH-1:0] best_reg, best_next;

    logic                  done_reg, done_next;
    fpba_pkg::result_t     result_reg, result_next;

    logic                  accept;
    logic                  load_wr;
    logic                  issue;
    logic [CNT_W-1:0]      limit_calc;
    logic [SIZE_WIDTH-1:0] ram_rdata;
    logic [SIZE_WIDTH-1:0] cap;
    logic [SIZE_WIDTH-1:0] left;
    logic                  take;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [SIZE_WIDTH-1:0] ram_wdata;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    assign load_wr = accept && (request.command == fpba_pkg::CMD_LOAD)
                     && (32'(request.block_select) < NUM_BLOCKS);

    // Saturate the search range to the store size.
    assign limit_calc = (32'(in_use_reg) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                       : CNT_W'(in_use_reg);

    assign issue = (state_reg == ST_SCAN) && (issue_reg < limit_reg);

    // Shared compare unit: a never-loaded entry reads as zero.
    assign cap  = valid_reg[rd_idx_reg] ? ram_rdata : '0;
    assign left = best_reg - amount_reg;

    always_comb
    begin
        take = 1'b0;
        if (cap >= amount_reg)
        begin
            if (!found_reg)
            begin
                take = 1'b1;
            end
            else if (policy_reg == fpba_pkg::POLICY_BEST)
            begin
                take = (cap < best_reg);
            end
            else if (policy_reg == fpba_pkg::POLICY_WORST)
            begin
                take = (cap > best_reg);
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        amount_next  = amount_reg;
        last_next    = last_reg;
        limit_next   = limit_reg;
        issue_next   = issue_reg;
        rd_vld_next  = issue;
        rd_last_next = issue && (issue_reg == limit_reg - CNT_W'(1));
        rd_idx_next  = issue_reg[IDX_W-1:0];
        found_next   = found_reg;
        pick_next    = pick_reg;
        best_next    = best_reg;
        done_next    = 1'b0;
        result_next  = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (request.command == fpba_pkg::CMD_ALLOC))
                begin
                    amount_next = SIZE_WIDTH'(request.amount);
                    last_next   = request.batch_last;
                    limit_next  = limit_calc;
                    issue_next  = '0;
                    found_next  = 1'b0;
                    pick_next   = '0;
                    best_next   = '0;
                    state_next  = (limit_calc == '0) ? ST_WRITE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (take)
                    begin
                        found_next = 1'b1;
                        pick_next  = rd_idx_reg;
                        best_next  = cap;
                    end
                    if (rd_last_reg)
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE:
            begin
                done_next             = 1'b1;
                result_next.granted   = found_reg;
                result_next.block_index = found_reg ? fpba_pkg::INDEX_W'(pick_reg) : '0;
                result_next.remaining = found_reg ? fpba_pkg::REMAIN_W'(left) : '0;
                result_next.batch_end = last_reg;
                state_next            = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Write port: loads in idle, write-back of the chosen block at the end of a search.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = IDX_W'(request.block_select);
        ram_wdata = SIZE_WIDTH'(request.amount);
        if (load_wr)
        begin
            ram_we = 1'b1;
        end
        else if ((state_reg == ST_WRITE) && found_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = pick_reg;
            ram_wdata = left;
        end
    end

    fpba_ram #(
        .WIDTH (SIZE_WIDTH),
        .DEPTH (NUM_BLOCKS),
        .AW    (IDX_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            policy_reg  <= fpba_pkg::POLICY_FIRST;
            in_use_reg  <= fpba_pkg::BLOCKS_IN_USE_RST;
            valid_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_vld_next;
            rd_last_reg <= rd_last_next;
            done_reg    <= done_next;
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fpba_pkg::REG_FIT_POLICY:
                    begin
                        policy_reg <= cfg_data[1:0];
                    end
                    fpba_pkg::REG_BLOCKS_IN_USE:
                    begin
                        in_use_reg <= cfg_data[3:0];
                    end
                    default:
                    begin
                        // drop writes beyond the register list
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        amount_reg <= amount_next;
        last_reg   <= last_next;
        limit_reg  <= limit_next;
        issue_reg  <= issue_next;
        rd_idx_reg <= rd_idx_next;
        found_reg  <= found_next;
        pick_reg   <= pick_next;
        best_reg   <= best_next;
        result_reg <= result_next;
    end

`ifndef SYNTHESIS
    a_done_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_WRITE))
        else $error("done without a write-back cycle");

    a_no_read_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !rd_vld_reg)
        else $error("capacity read in flight while idle");

    a_denied_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.granted) |-> (result.block_index == '0 && result.remaining == '0))
        else $error("denied result carries a block or capacity");

    a_write_back_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && found_reg) |=> valid_reg[$past(pick_reg)])
        else $error("written block not marked valid");
`endif

endmodule

`default_nettype wire
